[src/mlsga_pkg.sv]
// Package: shared widths and constants for the sparse grid accumulator
`default_nettype none
package mlsga_pkg;

    localparam int MAX_LEVEL_EXP   = 15;
    localparam int COORD_FRAC_BITS = 16;

    localparam int WEIGHT_W = 32;
    localparam int LEVEL_W  = 4;
    localparam int INDEX_W  = 15;
    localparam int COORD_W  = COORD_FRAC_BITS + 1;
    localparam int SUM_W    = 48;

    localparam int BASIS_W  = COORD_FRAC_BITS + 2;
    localparam int PROD_W   = 40;
    localparam int HALF_W   = PROD_W / 2;
    localparam int FULL_W   = PROD_W + BASIS_W;
    localparam int T_W      = COORD_W + MAX_LEVEL_EXP + 1;

    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef logic [LEVEL_W-1:0]         level_t;
    typedef logic [INDEX_W-1:0]         index_t;
    typedef logic [COORD_W-1:0]         coord_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

endpackage
`default_nettype wire

[src/mlsga_if.sv]
// Interfaces: input item channel and result channel
`default_nettype none
interface mlsga_item_if;
    logic                valid;
    logic                ready;
    mlsga_pkg::weight_t  weight;
    mlsga_pkg::level_t   level_exp;
    mlsga_pkg::index_t   point_index;
    mlsga_pkg::coord_t   coord;
    logic                last_dim;
    logic                last_point;

    modport source (output valid, weight, level_exp, point_index, coord, last_dim, last_point,
                    input ready);
    modport sink   (input valid, weight, level_exp, point_index, coord, last_dim, last_point,
                    output ready);
endinterface

interface mlsga_result_if;
    logic             valid;
    logic             ready;
    mlsga_pkg::sum_t  sum;

    modport source (output valid, sum, input ready);
    modport sink   (input valid, sum, output ready);
endinterface
`default_nettype wire

[src/modlinear_sparse_grid_accumulate.sv]
// Top level: modified linear sparse grid transposed evaluation for one grid point
//
// Channel item (sink): one word per dimension of one data point, with weight,
// level_exp, point_index, coord, last_dim and last_point. A word is taken when
// valid and ready are both high. Channel result (source): one sum word per grid
// point, sent after the word that has last_dim and last_point both set.
// Each word passes through accept, basis, low partial product, high partial
// product and saturate, and with last_dim set also accumulate. One 20x18 multiplier
// is shared by the two partial products; ready is high only in the idle state.
// A sum word is written from the accumulate step into an output
// register; the next input word is taken while it waits. If the receiver still
// holds off when the following sum is due, the block waits in its accumulate
// step. Reset empties the output register, clears the product and the sum and
// marks the next word as the first dimension of a point.
`default_nettype none
module modlinear_sparse_grid_accumulate (
    input  wire logic      clk,
    input  wire logic      rst_n,
    mlsga_item_if.sink     item,
    mlsga_result_if.source result
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_BASIS  = 6'b000010,
        S_MUL_LO = 6'b000100,
        S_MUL_HI = 6'b001000,
        S_FINISH = 6'b010000,
        S_ACC    = 6'b100000
    } state_t;

    localparam int F = mlsga_pkg::COORD_FRAC_BITS;
    localparam int PW = mlsga_pkg::PROD_W;
    localparam int HW = mlsga_pkg::HALF_W;
    localparam int BW = mlsga_pkg::BASIS_W;
    localparam int FW = mlsga_pkg::FULL_W;
    localparam int TW = mlsga_pkg::T_W;
    localparam int SW = mlsga_pkg::SUM_W;
    localparam int IW = mlsga_pkg::INDEX_W;

    state_t state_reg, state_next;

    mlsga_pkg::weight_t weight_reg;
    mlsga_pkg::level_t  level_reg;
    mlsga_pkg::index_t  index_reg;
    mlsga_pkg::coord_t  coord_reg;
    logic               last_dim_reg;
    logic               last_point_reg;

    logic               first_reg, first_next;
    logic signed [PW-1:0] rp_reg, rp_next;
    mlsga_pkg::sum_t    acc_reg, acc_next;
    logic [BW-1:0]      basis_reg, basis_next;
    logic [PW-1:0]      mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [FW-1:0]      prod_reg, prod_next;
    logic               out_valid_reg, out_valid_next;
    mlsga_pkg::sum_t    out_sum_reg, out_sum_next;

    logic [TW-1:0]      t, ip, one, r2, r3, d, v;
    logic [IW:0]        top_w;
    logic [IW-1:0]      top;
    logic signed [PW-1:0] rp_src;
    logic [HW-1:0]      mul_a;
    logic [HW+BW-1:0]   mul_p;
    logic [FW-F-1:0]    r;
    logic signed [SW:0] s_wide;
    mlsga_pkg::sum_t    s_sat;
    logic               take;
    logic               emit_blocked;

    always_comb
    begin
        one   = TW'(1) << F;
        t     = TW'(coord_reg) << level_reg;
        ip    = TW'(index_reg) << F;
        top_w = (IW + 1)'(1) << level_reg;
        top   = IW'(top_w - (IW + 1)'(1));
        r2    = ((one << 1) > t) ? (one << 1) - t : '0;
        r3    = ((t + one) > ip) ? t + one - ip : '0;
        d     = (t > ip) ? t - ip : ip - t;
        if (level_reg == mlsga_pkg::level_t'(1))
        begin
            v = one;
        end
        else if (index_reg == IW'(1))
        begin
            v = r2;
        end
        else if (index_reg == top)
        begin
            v = r3;
        end
        else
        begin
            v = (d < one) ? one - d : '0;
        end
        basis_next = (v > TW'({BW{1'b1}})) ? {BW{1'b1}} : BW'(v);
    end

    assign rp_src = first_reg ? PW'(weight_reg) : rp_reg;
    assign mul_a  = (state_reg == S_MUL_HI) ? mag_reg[PW-1:HW] : mag_reg[HW-1:0];
    assign mul_p  = (HW + BW)'(mul_a) * (HW + BW)'(basis_reg);
    assign r      = prod_reg[FW-1:F];
    assign s_wide = (SW + 1)'(rp_reg) + (SW + 1)'(acc_reg);

    always_comb
    begin
        if (s_wide[SW] != s_wide[SW-1])
        begin
            s_sat = s_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
        else
        begin
            s_sat = s_wide[SW-1:0];
        end
    end

    assign take         = item.valid && item.ready;
    assign emit_blocked = last_point_reg && out_valid_reg && !result.ready;

    always_comb
    begin
        state_next     = state_reg;
        first_next     = first_reg;
        rp_next        = rp_reg;
        acc_next       = acc_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        out_sum_next   = out_sum_reg;
        out_valid_next = out_valid_reg && !result.ready;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_BASIS;
                end
            end
            S_BASIS:
            begin
                neg_next   = rp_src[PW-1];
                mag_next   = rp_src[PW-1] ? PW'(0) - PW'(rp_src) : PW'(rp_src);
                state_next = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                prod_next  = FW'(mul_p);
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                prod_next  = prod_reg + (FW'(mul_p) << HW);
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (r[FW-F-1:PW-1] != '0)
                begin
                    rp_next = neg_reg ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
                end
                else
                begin
                    rp_next = neg_reg ? PW'(0) - PW'({1'b0, r[PW-2:0]})
                                      : PW'({1'b0, r[PW-2:0]});
                end
                first_next = last_dim_reg;
                state_next = last_dim_reg ? S_ACC : S_IDLE;
            end
            S_ACC:
            begin
                if (!last_point_reg)
                begin
                    acc_next   = s_sat;
                    state_next = S_IDLE;
                end
                else if (!emit_blocked)
                begin
                    out_sum_next   = s_sat;
                    out_valid_next = 1'b1;
                    acc_next       = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= 1'b1;
            rp_reg        <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            rp_reg        <= rp_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            weight_reg     <= item.weight;
            level_reg      <= item.level_exp;
            index_reg      <= item.point_index;
            coord_reg      <= item.coord;
            last_dim_reg   <= item.last_dim;
            last_point_reg <= item.last_point;
        end
        if (state_reg == S_BASIS)
        begin
            basis_reg <= basis_next;
        end
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        prod_reg    <= prod_next;
        out_sum_reg <= out_sum_next;
    end

    assign item.ready   = (state_reg == S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.sum   = out_sum_reg;

    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (state_reg == S_BASIS) && !item.ready)
        else $error("accepted word did not start the sequence");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) && last_point_reg && !emit_blocked
        |=> (acc_reg == '0) && out_valid_reg)
        else $error("emitted sum did not clear the accumulator");

    a_mid_point: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) && !last_dim_reg |=> !first_reg && (state_reg == S_IDLE))
        else $error("inner dimension restarted the point");

endmodule
`default_nettype wire
